FILE: design/hrcm_pkg.sv
// shared types, constants and the hue wheel decoder of the hue ramp color map
package hrcm_pkg;

  localparam int LEVEL_W   = 32;  // width of the level field on the stream
  localparam int FS_W      = 32;  // width of the full scale register
  localparam int REM_W     = 34;  // divider remainder, holds up to 3 * full scale
  localparam int POS_W     = 11;  // hue position 0..1536
  localparam int CH_W      = 8;
  localparam int SEG_W     = 3;
  localparam int FRAC_W    = 8;
  localparam int INT_STEPS = 2;   // quotient bits for floor(3 * level / full scale)
  localparam int DIV_STEPS = POS_W;

  localparam logic [FS_W-1:0]  FS_RESET = 32'd1536;
  localparam logic [FS_W-1:0]  FS_MIN   = 32'd1;
  localparam logic [POS_W-1:0] POS_MAX  = 11'd1536;
  localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;
  localparam logic [CH_W-1:0]  CH_ZERO  = 8'd0;

  localparam logic [SEG_W-1:0] SEG_RED_GREEN_UP  = 3'd0;
  localparam logic [SEG_W-1:0] SEG_RED_DOWN      = 3'd1;
  localparam logic [SEG_W-1:0] SEG_BLUE_UP       = 3'd2;
  localparam logic [SEG_W-1:0] SEG_GREEN_DOWN    = 3'd3;
  localparam logic [SEG_W-1:0] SEG_RED_UP        = 3'd4;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic             over;
    logic [REM_W-1:0] rem;
    logic [POS_W-1:0] quo;
  } div_word_t;

  // six segments of 256 steps; position 1536 lands in the default arm as magenta
  function automatic rgb_t hue_to_rgb(input logic [POS_W-1:0] pos);
    logic [SEG_W-1:0]  seg;
    logic [FRAC_W-1:0] f;
    rgb_t              c;
    seg = pos[POS_W-1:FRAC_W];
    f   = pos[FRAC_W-1:0];
    unique case (seg)
      SEG_RED_GREEN_UP: begin c.red = CH_MAX;     c.green = f;          c.blue = CH_ZERO;     end
      SEG_RED_DOWN:     begin c.red = CH_MAX - f; c.green = CH_MAX;     c.blue = CH_ZERO;     end
      SEG_BLUE_UP:      begin c.red = CH_ZERO;    c.green = CH_MAX;     c.blue = f;           end
      SEG_GREEN_DOWN:   begin c.red = CH_ZERO;    c.green = CH_MAX - f; c.blue = CH_MAX;      end
      SEG_RED_UP:       begin c.red = f;          c.green = CH_ZERO;    c.blue = CH_MAX;      end
      default:          begin c.red = CH_MAX;     c.green = CH_ZERO;    c.blue = CH_MAX - f;  end
    endcase
    return c;
  endfunction

endpackage

FILE: design/hrcm_prep.sv
// front stages: clamp the level to full scale, then form 3 * level for the divider
module hrcm_prep import hrcm_pkg::*; #(
  parameter int LEVEL_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic [FS_W-1:0]    fs_i,
  output logic               valid_o,
  input  logic               ready_i,
  output div_word_t          word_o
);

  logic [LEVEL_BITS-1:0] lvl_m;
  logic                  over_nxt;
  logic [LEVEL_BITS-1:0] lvl_nxt;
  logic [LEVEL_BITS-1:0] lvl_r;
  logic                  over_a_r;
  logic                  va_r;
  logic                  ready_a;
  logic                  ready_b;
  div_word_t             word_nxt;
  div_word_t             word_r;
  logic                  vb_r;

  assign lvl_m    = level_i[LEVEL_BITS-1:0];
  assign over_nxt = FS_W'(lvl_m) > fs_i;
  // when clamped, full scale is below the level and fits its width
  assign lvl_nxt  = over_nxt ? fs_i[LEVEL_BITS-1:0] : lvl_m;

  assign word_nxt.over = over_a_r;
  assign word_nxt.rem  = REM_W'(lvl_r) + (REM_W'(lvl_r) << 1);
  assign word_nxt.quo  = '0;

  assign ready_b = !vb_r || ready_i;
  assign ready_a = !va_r || ready_b;
  assign ready_o = ready_a;
  assign valid_o = vb_r;
  assign word_o  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= valid_i;
      if (ready_b) vb_r <= va_r;
    end
    if (ready_a && valid_i) begin
      lvl_r    <= lvl_nxt;
      over_a_r <= over_nxt;
    end
    if (ready_b && va_r) word_r <= word_nxt;
  end

endmodule

FILE: design/hrcm_div_step.sv
// one restoring division stage: one quotient bit per stage
module hrcm_div_step import hrcm_pkg::*; #(
  parameter bit          PRE_SHIFT = 1'b0,
  parameter int unsigned DIV_SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  div_word_t       word_i,
  input  logic [FS_W-1:0] fs_i,
  output logic            valid_o,
  input  logic            ready_i,
  output div_word_t       word_o
);

  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] divisor;
  logic             ge;
  div_word_t        word_nxt;
  div_word_t        word_r;
  logic             valid_r;

  assign trial   = PRE_SHIFT ? (word_i.rem << 1) : word_i.rem;
  assign divisor = REM_W'(fs_i) << DIV_SHIFT;
  assign ge      = trial >= divisor;

  assign word_nxt.over = word_i.over;
  assign word_nxt.rem  = ge ? (trial - divisor) : trial;
  assign word_nxt.quo  = {word_i.quo[POS_W-2:0], ge};

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign word_o  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) word_r <= word_nxt;
  end

endmodule

FILE: design/hrcm_color.sv
// output stage: hue position to rgb, registered on the result channel
module hrcm_color import hrcm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  output logic      ready_o,
  input  div_word_t word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output rgb_t      color_o,
  output logic      over_o
);

  rgb_t color_r;
  logic over_r;
  logic valid_r;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign color_o = color_r;
  assign over_o  = over_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
    if (ready_o && valid_i) begin
      color_r <= hue_to_rgb(word_i.quo);
      over_r  <= word_i.over;
    end
  end

endmodule

FILE: design/hue_ramp_color_map_core.sv
// hue ramp color map top level: level stream in, rainbow rgb stream out
// an input transfer passes the front stages, the 11 divide stages and the color stage
// throughput: one transfer per cycle; each stage holds its item while the next one is full
// the 11 restoring division stages, one quotient bit each, set the depth
// reset (rst_n low, synchronous): pipeline emptied, full_scale back to 1536
module hue_ramp_color_map_core import hrcm_pkg::*; #(
  parameter int LEVEL_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // level stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [LEVEL_W-1:0] in_tdata,   // [31:0] level
  // color stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [3*CH_W-1:0]  out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic               out_tuser,  // [0] over_range
  // full scale register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [FS_W-1:0]    cfg_data    // [31:0] full_scale
);

  // full scale register; zero is stored as one so the divider never sees zero
  logic [FS_W-1:0] fs_r;
  logic [FS_W-1:0] fs_nxt;

  assign cfg_ready = 1'b1;
  assign fs_nxt    = (cfg_data == '0) ? FS_MIN : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fs_r <= fs_nxt;
    end
  end

  // divider chain, index 0 is the front stage output
  div_word_t div_w   [DIV_STEPS+1];
  logic      div_v   [DIV_STEPS+1];
  logic      div_rdy [DIV_STEPS+1];

  hrcm_prep #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .level_i (in_tdata),
    .fs_i    (fs_r),
    .valid_o (div_v[0]),
    .ready_i (div_rdy[0]),
    .word_o  (div_w[0])
  );

  // pos = floor(3 * level / fs) * 512 + floor(512 * rem / fs)
  // first step tests against 2 * fs, second against fs, then 9 fraction steps
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    hrcm_div_step #(
      .PRE_SHIFT (i >= INT_STEPS),
      .DIV_SHIFT ((i == 0) ? 1 : 0)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_v[i]),
      .ready_o (div_rdy[i]),
      .word_i  (div_w[i]),
      .fs_i    (fs_r),
      .valid_o (div_v[i+1]),
      .ready_i (div_rdy[i+1]),
      .word_o  (div_w[i+1])
    );
  end

  rgb_t color;

  hrcm_color u_color (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (div_v[DIV_STEPS]),
    .ready_o (div_rdy[DIV_STEPS]),
    .word_i  (div_w[DIV_STEPS]),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .color_o (color),
    .over_o  (out_tuser)
  );

  assign out_tdata = color;

  // the hue position never passes the end of the wheel
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[DIV_STEPS] |-> div_w[DIV_STEPS].quo <= POS_MAX)
    else $error("hue position beyond end of wheel");

  // a clamped level always lands exactly on the end of the wheel
  a_over_pos: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[DIV_STEPS] && div_w[DIV_STEPS].over |-> div_w[DIV_STEPS].quo == POS_MAX)
    else $error("clamped level not at end of wheel");

  // an empty output stage lets the whole chain move
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule

FILE: verif/hue_ramp_color_map_core_test.sv
// self-checking stream testbench for the hue ramp color map core
`timescale 1ns / 1ps

module hue_ramp_color_map_core_test;
  import hrcm_pkg::*;

  localparam int LEVEL_BITS = 32;
  localparam int PHASE_ITEMS = 144;   // random levels per full scale setting
  localparam int SETTLE_CYCLES = 30;  // comfortably past the time the pipeline takes to drain

  // one expected color transfer, channels as they come out of the block
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            over;
  } hue_color_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [LEVEL_W-1:0] in_tdata = '0;    // [31:0] level
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [3*CH_W-1:0]  out_tdata;        // [7:0] red, [15:8] green, [23:16] blue
  logic               out_tuser;        // [0] over_range
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FS_W-1:0]    cfg_data = '0;    // [31:0] full_scale

  logic [LEVEL_W-1:0] pending_levels [$];  // levels not yet offered to the block
  hue_color_t         colors_due [$];      // colors owed by the block, oldest first
  logic [FS_W-1:0]    scale_now;           // our copy of the full scale register
  bit                 level_taken;         // level transfer seen at the last rising edge
  bit                 no_gaps;             // both sides run flat out while set
  int                 mismatch_count;

  // levels that hit every segment boundary with the reset full scale of 1536
  logic [LEVEL_W-1:0] wheel_marks [16] = '{
    32'd0, 32'd1, 32'd255, 32'd256, 32'd511, 32'd512, 32'd767, 32'd768,
    32'd1023, 32'd1024, 32'd1279, 32'd1280, 32'd1535, 32'd1536, 32'd1537,
    32'hFFFF_FFFF
  };

  hue_ramp_color_map_core #(.LEVEL_BITS(LEVEL_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // color for one level: clamp, exact quotient onto the 1536 step wheel, segment decode
  function automatic hue_color_t predict_color(input logic [LEVEL_W-1:0] level,
                                               input logic [FS_W-1:0] scale);
    logic [63:0]       lvl;
    logic [63:0]       fs;
    logic [63:0]       pos_wide;
    logic [POS_W-1:0]  pos;
    logic [FRAC_W-1:0] f;
    hue_color_t        c;
    lvl = 64'(level) & ((64'd1 << LEVEL_BITS) - 64'd1);
    // zero full scale behaves as one
    fs = (scale == '0) ? 64'd1 : 64'(scale);
    c.over = (lvl > fs);
    if (c.over) begin
      lvl = fs;
    end
    pos_wide = (lvl * 64'(POS_MAX)) / fs;
    pos = pos_wide[POS_W-1:0];
    f = pos[FRAC_W-1:0];
    case (pos[POS_W-1:FRAC_W])
      SEG_RED_GREEN_UP: begin c.red = CH_MAX;     c.green = f;          c.blue = CH_ZERO;    end
      SEG_RED_DOWN:     begin c.red = CH_MAX - f; c.green = CH_MAX;     c.blue = CH_ZERO;    end
      SEG_BLUE_UP:      begin c.red = CH_ZERO;    c.green = CH_MAX;     c.blue = f;          end
      SEG_GREEN_DOWN:   begin c.red = CH_ZERO;    c.green = CH_MAX - f; c.blue = CH_MAX;     end
      SEG_RED_UP:       begin c.red = f;          c.green = CH_ZERO;    c.blue = CH_MAX;     end
      // last segment, and the wheel end at 1536, fade blue out of magenta
      default:          begin c.red = CH_MAX;     c.green = CH_ZERO;    c.blue = CH_MAX - f; end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // block until every level is in and every color is out
  task automatic wait_drained();
    while (pending_levels.size() != 0 || colors_due.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
  endtask

  // register write, only once the pipeline has emptied out
  task automatic set_full_scale(input logic [FS_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random levels: mostly in range or near the clamp point and segment edges,
  // the rest anywhere in the 32 bit field
  task automatic queue_random_levels(input int count);
    logic [FS_W-1:0]    fs_eff;
    logic [63:0]        mark;
    logic [LEVEL_W-1:0] lvl;
    fs_eff = (scale_now == '0) ? 32'd1 : scale_now;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: lvl = $urandom;
        1: lvl = $urandom_range(fs_eff, 0);
        2: lvl = fs_eff + $urandom_range(4) - 32'd2;
        default: begin
          mark = (64'(fs_eff) * 64'($urandom_range(6))) / 64'd6;
          lvl  = mark[LEVEL_W-1:0] + $urandom_range(2) - 32'd1;
        end
      endcase
      pending_levels.push_back(lvl);
    end
  endtask

  // sampling side: register writes, level transfers and color checks at the rising edge
  always @(posedge clk) begin
    hue_color_t want;
    if (!rst_n) begin
      scale_now = FS_RESET;
      level_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_now = cfg_data;
      end
      // results first, so a level taken on this edge never matches an older color
      if (out_tvalid && out_tready) begin
        if (colors_due.size() == 0) begin
          report_mismatch("color transfer with none due", int'(out_tdata), 0);
        end else begin
          want = colors_due.pop_front();
          if (out_tdata[CH_W-1:0] !== want.red) begin
            report_mismatch("red", int'(out_tdata[CH_W-1:0]), int'(want.red));
          end
          if (out_tdata[2*CH_W-1:CH_W] !== want.green) begin
            report_mismatch("green", int'(out_tdata[2*CH_W-1:CH_W]), int'(want.green));
          end
          if (out_tdata[3*CH_W-1:2*CH_W] !== want.blue) begin
            report_mismatch("blue", int'(out_tdata[3*CH_W-1:2*CH_W]), int'(want.blue));
          end
          if (out_tuser !== want.over) begin
            report_mismatch("over_range", int'(out_tuser), int'(want.over));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        colors_due.push_back(predict_color(in_tdata, scale_now));
        level_taken = 1'b1;
      end
    end
  end

  // driving side: level source and color sink both change on the falling edge
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 33);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || level_taken) begin
      // the offered level is gone (or none was up), pick the next one or a gap
      level_taken = 1'b0;
      if (pending_levels.size() != 0 && (no_gaps || $urandom_range(99) >= 33)) begin
        in_tdata  <= pending_levels.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // stimulus: directed corners, then random levels under a range of full scales
  initial begin
    logic [FS_W-1:0] scales [8];
    mismatch_count = 0;
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // levels on both sides of each segment edge, plus clamps just past full scale and at the top
    set_full_scale(FS_RESET);
    foreach (wheel_marks[i]) pending_levels.push_back(wheel_marks[i]);

    // zero full scale acts as one: red at zero, magenta above, flagged from two up
    set_full_scale(32'd0);
    pending_levels.push_back(32'd0);
    pending_levels.push_back(32'd1);
    pending_levels.push_back(32'd2);
    pending_levels.push_back(32'hFFFF_FFFF);

    // widest full scale, where the product level * 1536 needs more than 32 bits
    set_full_scale(32'hFFFF_FFFF);
    pending_levels.push_back(32'd0);
    pending_levels.push_back(32'hFFFF_FFFF);
    pending_levels.push_back(32'h7FFF_FFFF);
    pending_levels.push_back(32'h2AAA_AAAA);

    scales[0] = FS_MIN;
    scales[1] = FS_RESET;
    scales[2] = 32'd0;
    scales[3] = 32'hFFFF_FFFF;
    scales[4] = $urandom;
    scales[5] = $urandom_range(5000, 2);
    scales[6] = 32'd1 << $urandom_range(31, 0);
    scales[7] = $urandom_range(32'hFFFF_FFFE, 32'h8000_0000);
    foreach (scales[p]) begin
      set_full_scale(scales[p]);
      // one setting runs without any idling on either side
      no_gaps = (p == 1);
      queue_random_levels(PHASE_ITEMS);
    end

    wait_drained();
    no_gaps = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond any correct run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: hue_ramp_color_map_core.f
design/hrcm_pkg.sv
design/hrcm_prep.sv
design/hrcm_div_step.sv
design/hrcm_color.sv
design/hue_ramp_color_map_core.sv
verif/hue_ramp_color_map_core_test.sv
